// File: rtl/bsst_pkg.sv
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared constants and types of the bounded set span tracker.
// ----------------------------------------------------------------------------
package bsst_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 11;
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0]  CAP_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ENTRIES);
  localparam logic [DATA_W-1:0] GAP_RESET = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } bsst_state_t;

  typedef struct packed {
    logic                     go;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } bsst_scan_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] gap;
  } bsst_scan_rsp_t;

endpackage

// File: rtl/bsst_ram.sv
// ----------------------------------------------------------------------------
// bsst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bsst_gap_scan.sv
// ----------------------------------------------------------------------------
// bsst_gap_scan
// Walks the stored entries, one read a cycle, and keeps the smallest
// absolute difference between the new value and any held value.
// ----------------------------------------------------------------------------
module bsst_gap_scan
  import bsst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  bsst_scan_req_t        req,
  output logic [ADDR_W-1:0]     raddr,
  input  logic [DATA_W-1:0]     rdata,
  output bsst_scan_rsp_t        rsp
);

  logic signed [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]         n_r;
  logic [ADDR_W-1:0]        idx_r;
  logic                     issue_r;
  logic                     rv_r;
  logic                     rlast_r;
  logic                     gv_r;
  logic                     glast_r;
  logic [DATA_W-1:0]        gs_r;
  logic [DATA_W-1:0]        gap_r;
  logic                     done_r;

  logic                     last;
  logic signed [DATA_W:0]   d_ab;
  logic signed [DATA_W:0]   d_ba;
  logic [DATA_W-1:0]        gs_nxt;

  assign raddr = idx_r;
  assign last  = ({1'b0, idx_r} == (n_r - CNT_W'(1)));

  // exact 33-bit difference, pick the non-negative side
  assign d_ab   = {value_r[DATA_W-1], value_r} - {rdata[DATA_W-1], rdata};
  assign d_ba   = {rdata[DATA_W-1], rdata} - {value_r[DATA_W-1], value_r};
  assign gs_nxt = d_ab[DATA_W] ? d_ba[DATA_W-1:0] : d_ab[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      rv_r    <= 1'b0;
      rlast_r <= 1'b0;
      gv_r    <= 1'b0;
      glast_r <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
      gap_r   <= GAP_RESET;
    end else begin
      if (req.go) begin
        issue_r <= 1'b1;
        idx_r   <= '0;
      end else if (issue_r) begin
        idx_r <= idx_r + ADDR_W'(1);
        if (last) begin
          issue_r <= 1'b0;
        end
      end
      rv_r    <= issue_r;
      rlast_r <= issue_r && last;
      gv_r    <= rv_r;
      glast_r <= rlast_r;
      if (gv_r && (gs_r < gap_r)) begin
        gap_r <= gs_r;
      end
      done_r <= gv_r && glast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      value_r <= req.value;
      n_r     <= req.count;
    end
    if (rv_r) begin
      gs_r <= gs_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.gap  = gap_r;

endmodule

// File: rtl/bounded_set_span_tracker.sv
// ----------------------------------------------------------------------------
// bounded_set_span_tracker
// Bounded set of signed 32-bit values with running min, max and smallest
// pairwise difference.
//
//   channel  dir  handshake        payload
//   in_      in   valid / stall    value
//   out_     out  valid / stall    status, held_count, spans_valid,
//                                  longest_span, shortest_span
//   cfg_     in   valid / ready    data (capacity)
//
// One item at a time. An accepted value with values already held reaches
// its result beat after the walk over the value RAM, one read a cycle; a
// rejected item or the first value skips the walk and goes to done.
// Synchronous active-low reset empties the set; RAM contents are not cleared.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits for the register before finishing.
// ----------------------------------------------------------------------------
module bounded_set_span_tracker
  import bsst_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_status,
  output logic [CNT_W-1:0]         out_held_count,
  output logic                     out_spans_valid,
  output logic [DATA_W-1:0]        out_longest_span,
  output logic [DATA_W-1:0]        out_shortest_span,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_data
);

  bsst_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]         cap_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;
  logic signed [DATA_W-1:0] value_r;
  logic                     full_r;
  logic                     out_valid_r;

  logic                     in_acc;
  logic                     full;
  logic                     finish;
  logic                     spans_ok;
  logic [DATA_W:0]          span;
  bsst_scan_req_t           scan_req;
  bsst_scan_rsp_t           scan_rsp;
  logic [ADDR_W-1:0]        raddr;
  logic [DATA_W-1:0]        rdata;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign full      = (count_r >= cap_r) || (count_r >= CNT_MAX);
  assign finish    = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign scan_req.go    = in_acc && !full && (count_r != '0);
  assign scan_req.value = in_value;
  assign scan_req.count = count_r;

  bsst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc && !full),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  bsst_gap_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scan_req),
    .raddr (raddr),
    .rdata (rdata),
    .rsp   (scan_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = scan_req.go ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    if (!full_r) begin
      count_nxt = count_r + CNT_W'(1);
      if (count_r == '0) begin
        min_nxt = value_r;
        max_nxt = value_r;
      end else begin
        if (value_r < min_r) begin
          min_nxt = value_r;
        end
        if (value_r > max_r) begin
          max_nxt = value_r;
        end
      end
    end
  end

  assign spans_ok = (count_nxt >= CNT_W'(2));
  assign span     = {max_nxt[DATA_W-1], max_nxt} - {min_nxt[DATA_W-1], min_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (finish) begin
        count_r     <= count_nxt;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r <= in_value;
      full_r  <= full;
    end
    if (finish) begin
      out_status        <= full_r;
      out_held_count    <= count_nxt;
      out_spans_valid   <= spans_ok;
      out_longest_span  <= spans_ok ? span[DATA_W-1:0] : '0;
      out_shortest_span <= spans_ok ? scan_rsp.gap : '0;
    end
  end

  assign out_valid = out_valid_r;

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_rsp.done |-> (state_r == ST_SCAN))
    else $error("gap scan finished outside the scan state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("held count above store depth");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && full_r) |=> $stable(count_r))
    else $error("rejected beat changed the held count");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_spans_valid) |-> (out_longest_span >= out_shortest_span))
    else $error("shortest span above longest span");

endmodule
